// File: rtl/aabb_pkg.sv
// Package for the AABB side collision latch: shared constants, register indexes and types.
// Used by every module in rtl/; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package aabb_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int ID_BITS_DEF    = 8;
	localparam int DIM_BITS       = 12;
	localparam int MARGIN_BITS    = 4;
	localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = 4'd2;

	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = MARGIN_BITS;
	localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE_MODE = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_EDGE_MARGIN  = 1'd1;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	localparam logic MODE_A_MOVES = 1'b0;
	localparam logic MODE_B_MOVES = 1'b1;

	typedef enum logic [1:0] {
		SIDE_TOP    = 2'd0,
		SIDE_BOTTOM = 2'd1,
		SIDE_LEFT   = 2'd2,
		SIDE_RIGHT  = 2'd3
	} side_t;

	typedef struct packed {
		logic  hit;
		side_t side;
	} cls_t;

	localparam int CLS_BITS = $bits(cls_t);

endpackage
`default_nettype wire

// File: rtl/aabb_side_collision_latch_top.sv
// An accepted word passes the front register, the queue and the output register.
// Throughput with out_stall low: one word per cycle in and one queue word out.
// A two-word queue parts the classifying front end from the latch back end.
// Reset (arst_n low, asynchronous): latches clear, saved positions and ids zero,
// release_mode 0, edge_margin 2, queue and output empty.
`timescale 1ns / 1ps
`default_nettype none
module aabb_side_collision_latch_top #(
	parameter int COORD_BITS = aabb_pkg::COORD_BITS_DEF,
	parameter int ID_BITS    = aabb_pkg::ID_BITS_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_we,
	input  wire  [aabb_pkg::CFG_IDX_BITS-1:0]     cfg_idx,
	input  wire  [aabb_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire  signed [COORD_BITS-1:0]          a_x,
	input  wire  signed [COORD_BITS-1:0]          a_y,
	input  wire  [aabb_pkg::DIM_BITS-1:0]         a_w,
	input  wire  [aabb_pkg::DIM_BITS-1:0]         a_h,
	input  wire  signed [COORD_BITS-1:0]          b_x,
	input  wire  signed [COORD_BITS-1:0]          b_y,
	input  wire  [aabb_pkg::DIM_BITS-1:0]         b_w,
	input  wire  [aabb_pkg::DIM_BITS-1:0]         b_h,
	input  wire  [ID_BITS-1:0]                    other_id,
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output logic                                  can_move_up,
	output logic                                  can_move_down,
	output logic                                  can_move_left,
	output logic                                  can_move_right,
	output logic                                  touch_top,
	output logic                                  touch_bottom,
	output logic                                  touch_left,
	output logic                                  touch_right
);

	localparam int QW = aabb_pkg::CLS_BITS + 4 * COORD_BITS + ID_BITS;

	logic                             release_mode_q;
	logic [aabb_pkg::MARGIN_BITS-1:0] edge_margin_q;
	logic                             q_push, q_full, q_pop, q_valid;
	logic [QW-1:0]                    q_din, q_dout;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			release_mode_q <= aabb_pkg::MODE_A_MOVES;
			edge_margin_q  <= aabb_pkg::MARGIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				aabb_pkg::REG_RELEASE_MODE: begin
					release_mode_q <= cfg_data[0];
				end
				aabb_pkg::REG_EDGE_MARGIN: begin
					edge_margin_q <= cfg_data[aabb_pkg::MARGIN_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	aabb_front #(
		.COORD_BITS (COORD_BITS),
		.ID_BITS    (ID_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.edge_margin (edge_margin_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.a_x         (a_x),
		.a_y         (a_y),
		.a_w         (a_w),
		.a_h         (a_h),
		.b_x         (b_x),
		.b_y         (b_y),
		.b_w         (b_w),
		.b_h         (b_h),
		.other_id    (other_id),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_din       (q_din)
	);

	aabb_q #(
		.W (QW)
	) u_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.dout   (q_dout)
	);

	aabb_back #(
		.COORD_BITS (COORD_BITS),
		.ID_BITS    (ID_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.release_mode   (release_mode_q),
		.q_valid        (q_valid),
		.q_dout         (q_dout),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.can_move_up    (can_move_up),
		.can_move_down  (can_move_down),
		.can_move_left  (can_move_left),
		.can_move_right (can_move_right),
		.touch_top      (touch_top),
		.touch_bottom   (touch_bottom),
		.touch_left     (touch_left),
		.touch_right    (touch_right)
	);

endmodule
`default_nettype wire

// File: rtl/aabb_front.sv
// Front end: grows both rectangles, tests overlap and picks the side of least penetration;
// a tie for least gives no hit. Depends on aabb_pkg; feeds the word queue.
`timescale 1ns / 1ps
`default_nettype none
module aabb_front #(
	parameter int COORD_BITS = aabb_pkg::COORD_BITS_DEF,
	parameter int ID_BITS    = aabb_pkg::ID_BITS_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire  [aabb_pkg::MARGIN_BITS-1:0]      edge_margin,
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire  signed [COORD_BITS-1:0]          a_x,
	input  wire  signed [COORD_BITS-1:0]          a_y,
	input  wire  [aabb_pkg::DIM_BITS-1:0]         a_w,
	input  wire  [aabb_pkg::DIM_BITS-1:0]         a_h,
	input  wire  signed [COORD_BITS-1:0]          b_x,
	input  wire  signed [COORD_BITS-1:0]          b_y,
	input  wire  [aabb_pkg::DIM_BITS-1:0]         b_w,
	input  wire  [aabb_pkg::DIM_BITS-1:0]         b_h,
	input  wire  [ID_BITS-1:0]                    other_id,
	input  wire                                   q_full,
	output logic                                  q_push,
	output logic [aabb_pkg::CLS_BITS+4*COORD_BITS+ID_BITS-1:0] q_din
);

	localparam int GW = aabb_pkg::DIM_BITS + 1;
	localparam int EW = ((COORD_BITS > GW + 1) ? COORD_BITS : GW + 1) + 1;
	localparam int PW = EW + 1;

	logic [GW-1:0] aw_g, ah_g, bw_g, bh_g;
	logic signed [EW-1:0] ax_in, ay_in, bx_in, by_in;

	logic                         vld_s1;
	logic signed [COORD_BITS-1:0] ax_s1, ay_s1, bx_s1, by_s1;
	logic signed [EW-1:0]         ar_s1, ab_s1, br_s1, bb_s1;
	logic [ID_BITS-1:0]           id_s1;

	logic signed [EW-1:0] ax_e, ay_e, bx_e, by_e;
	logic signed [PW-1:0] pen_top, pen_bot, pen_lft, pen_rgt;
	logic                 overlap;
	logic [3:0]           sm;
	aabb_pkg::cls_t       cls;
	logic                 adv;

	assign aw_g = GW'(a_w) + GW'(edge_margin);
	assign ah_g = GW'(a_h) + GW'(edge_margin);
	assign bw_g = GW'(b_w) + GW'(edge_margin);
	assign bh_g = GW'(b_h) + GW'(edge_margin);
	assign ax_in = EW'(a_x);
	assign ay_in = EW'(a_y);
	assign bx_in = EW'(b_x);
	assign by_in = EW'(b_y);

	assign q_push   = vld_s1 && !q_full;
	assign adv      = !vld_s1 || !q_full;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			ax_s1 <= a_x;
			ay_s1 <= a_y;
			bx_s1 <= b_x;
			by_s1 <= b_y;
			ar_s1 <= ax_in + signed'(EW'(aw_g));
			ab_s1 <= ay_in + signed'(EW'(ah_g));
			br_s1 <= bx_in + signed'(EW'(bw_g));
			bb_s1 <= by_in + signed'(EW'(bh_g));
			id_s1 <= other_id;
		end
	end

	assign ax_e = EW'(ax_s1);
	assign ay_e = EW'(ay_s1);
	assign bx_e = EW'(bx_s1);
	assign by_e = EW'(by_s1);

	assign overlap = (ax_e < br_s1) && (ar_s1 > bx_e) && (ay_e < bb_s1) && (ab_s1 > by_e);

	assign pen_top = PW'(ab_s1) - PW'(by_e);
	assign pen_bot = PW'(bb_s1) - PW'(ay_e);
	assign pen_lft = PW'(ar_s1) - PW'(bx_e);
	assign pen_rgt = PW'(br_s1) - PW'(ax_e);

	assign sm[0] = (pen_top < pen_bot) && (pen_top < pen_lft) && (pen_top < pen_rgt);
	assign sm[1] = (pen_bot < pen_top) && (pen_bot < pen_lft) && (pen_bot < pen_rgt);
	assign sm[2] = (pen_lft < pen_top) && (pen_lft < pen_bot) && (pen_lft < pen_rgt);
	assign sm[3] = (pen_rgt < pen_top) && (pen_rgt < pen_bot) && (pen_rgt < pen_lft);

	always_comb begin
		cls.hit = overlap && (|sm);
		priority if (sm[0]) begin
			cls.side = aabb_pkg::SIDE_TOP;
		end else if (sm[1]) begin
			cls.side = aabb_pkg::SIDE_BOTTOM;
		end else if (sm[2]) begin
			cls.side = aabb_pkg::SIDE_LEFT;
		end else begin
			cls.side = aabb_pkg::SIDE_RIGHT;
		end
	end

	assign q_din = {cls, ax_s1, ay_s1, bx_s1, by_s1, id_s1};

endmodule
`default_nettype wire

// File: rtl/aabb_q.sv
// Two-entry word queue between the front end and the latch back end.
// Depends on aabb_pkg for depth and pointer widths.
`timescale 1ns / 1ps
`default_nettype none
module aabb_q #(
	parameter int W = 8
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          push,
	input  wire  [W-1:0] din,
	output logic         full,
	input  wire          pop,
	output logic         valid,
	output logic [W-1:0] dout
);

	logic [W-1:0]                  mem_q [aabb_pkg::QDEPTH];
	logic [aabb_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [aabb_pkg::QCNT_W-1:0]   count_q;

	assign full  = (count_q == aabb_pkg::QCNT_W'(aabb_pkg::QDEPTH));
	assign valid = (count_q != '0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid)
		else $error("queue read while empty");
`endif

endmodule
`default_nettype wire

// File: rtl/aabb_back.sv
// Back end: side latches, release checks and the registered result word.
// Depends on aabb_pkg; drains the word queue.
`timescale 1ns / 1ps
`default_nettype none
module aabb_back #(
	parameter int COORD_BITS = aabb_pkg::COORD_BITS_DEF,
	parameter int ID_BITS    = aabb_pkg::ID_BITS_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                release_mode,
	input  wire                q_valid,
	input  wire  [aabb_pkg::CLS_BITS+4*COORD_BITS+ID_BITS-1:0] q_dout,
	output logic               q_pop,
	output logic               out_valid,
	input  wire                out_stall,
	output logic               can_move_up,
	output logic               can_move_down,
	output logic               can_move_left,
	output logic               can_move_right,
	output logic               touch_top,
	output logic               touch_bottom,
	output logic               touch_left,
	output logic               touch_right
);

	aabb_pkg::cls_t               cls;
	logic signed [COORD_BITS-1:0] ax, ay, bx, by;
	logic [ID_BITS-1:0]           id;

	logic                         latched_q [4];
	logic signed [COORD_BITS-1:0] sax_q [4];
	logic signed [COORD_BITS-1:0] say_q [4];
	logic signed [COORD_BITS-1:0] sbx_q [4];
	logic signed [COORD_BITS-1:0] sby_q [4];
	logic [ID_BITS-1:0]           sid_q [4];

	logic                         hit_s   [4];
	logic                         lat_n   [4];
	logic signed [COORD_BITS-1:0] sax_n   [4];
	logic signed [COORD_BITS-1:0] say_n   [4];
	logic signed [COORD_BITS-1:0] sbx_n   [4];
	logic signed [COORD_BITS-1:0] sby_n   [4];
	logic [ID_BITS-1:0]           sid_n   [4];
	logic                         act     [4];
	logic                         rel     [4];
	logic                         lat_new [4];

	logic out_valid_q;

	assign {cls, ax, ay, bx, by, id} = q_dout;
	assign q_pop     = q_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	always_comb begin
		for (int s = 0; s < 4; s++) begin
			hit_s[s] = cls.hit && (cls.side == aabb_pkg::side_t'(s));
			lat_n[s] = latched_q[s] || hit_s[s];
			sax_n[s] = hit_s[s] ? ax : sax_q[s];
			say_n[s] = hit_s[s] ? ay : say_q[s];
			sbx_n[s] = hit_s[s] ? bx : sbx_q[s];
			sby_n[s] = hit_s[s] ? by : sby_q[s];
			sid_n[s] = hit_s[s] ? id : sid_q[s];
			act[s]   = lat_n[s] &&
				((release_mode == aabb_pkg::MODE_A_MOVES) || (sid_n[s] == id));
		end
		if (release_mode == aabb_pkg::MODE_A_MOVES) begin
			rel[aabb_pkg::SIDE_TOP]    = (ay < say_n[aabb_pkg::SIDE_TOP]) ||
				(ax != sax_n[aabb_pkg::SIDE_TOP]);
			rel[aabb_pkg::SIDE_BOTTOM] = (ay > say_n[aabb_pkg::SIDE_BOTTOM]) ||
				(ax != sax_n[aabb_pkg::SIDE_BOTTOM]);
			rel[aabb_pkg::SIDE_LEFT]   = (ax < sax_n[aabb_pkg::SIDE_LEFT]) ||
				(ay != say_n[aabb_pkg::SIDE_LEFT]);
			rel[aabb_pkg::SIDE_RIGHT]  = (ax > sax_n[aabb_pkg::SIDE_RIGHT]) ||
				(ay != say_n[aabb_pkg::SIDE_RIGHT]);
		end else begin
			rel[aabb_pkg::SIDE_TOP]    = (by > sby_n[aabb_pkg::SIDE_TOP]) ||
				(bx != sbx_n[aabb_pkg::SIDE_TOP]);
			rel[aabb_pkg::SIDE_BOTTOM] = (by < sby_n[aabb_pkg::SIDE_BOTTOM]) ||
				(bx != sbx_n[aabb_pkg::SIDE_BOTTOM]);
			rel[aabb_pkg::SIDE_LEFT]   = (bx > sbx_n[aabb_pkg::SIDE_LEFT]) ||
				(by != sby_n[aabb_pkg::SIDE_LEFT]);
			rel[aabb_pkg::SIDE_RIGHT]  = (bx < sbx_n[aabb_pkg::SIDE_RIGHT]) ||
				(by != sby_n[aabb_pkg::SIDE_RIGHT]);
		end
		for (int s = 0; s < 4; s++) begin
			lat_new[s] = lat_n[s] && !(act[s] && rel[s]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < 4; s++) begin
				latched_q[s] <= 1'b0;
				sax_q[s]     <= '0;
				say_q[s]     <= '0;
				sbx_q[s]     <= '0;
				sby_q[s]     <= '0;
				sid_q[s]     <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				for (int s = 0; s < 4; s++) begin
					latched_q[s] <= lat_new[s];
					sax_q[s]     <= sax_n[s];
					say_q[s]     <= say_n[s];
					sbx_q[s]     <= sbx_n[s];
					sby_q[s]     <= sby_n[s];
					sid_q[s]     <= sid_n[s];
				end
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			can_move_up    <= !act[aabb_pkg::SIDE_BOTTOM];
			can_move_down  <= !act[aabb_pkg::SIDE_TOP];
			can_move_left  <= !act[aabb_pkg::SIDE_RIGHT];
			can_move_right <= !act[aabb_pkg::SIDE_LEFT];
			touch_top      <= lat_new[aabb_pkg::SIDE_TOP];
			touch_bottom   <= lat_new[aabb_pkg::SIDE_BOTTOM];
			touch_left     <= lat_new[aabb_pkg::SIDE_LEFT];
			touch_right    <= lat_new[aabb_pkg::SIDE_RIGHT];
		end
	end

`ifndef SYNTHESIS
	a_hit_latches: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && cls.hit |=> latched_q[$past(cls.side)])
		else $error("fresh hit not latched");
	a_touch_matches: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (touch_top == latched_q[aabb_pkg::SIDE_TOP]) &&
			(touch_bottom == latched_q[aabb_pkg::SIDE_BOTTOM]) &&
			(touch_left == latched_q[aabb_pkg::SIDE_LEFT]) &&
			(touch_right == latched_q[aabb_pkg::SIDE_RIGHT]))
		else $error("touch flags disagree with latch state");
	a_pop_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> out_valid_q)
		else $error("popped word not presented");
	a_block_needs_latch: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && !cls.hit && !latched_q[aabb_pkg::SIDE_TOP] |=> can_move_down)
		else $error("top blocked without a latch");
`endif

endmodule
`default_nettype wire

// File: tb/tb_aabb_side_collision_latch_top.sv
`timescale 1ns / 1ps
// Self-checking bench for aabb_side_collision_latch_top: rectangle pairs in, movement and touch
// flags out, checked word by word against a scoreboard class that tracks the side latches.
// Depends on rtl/aabb_pkg.sv and rtl/aabb_side_collision_latch_top.sv.
module tb_aabb_side_collision_latch_top;
	import aabb_pkg::*;

	localparam int CW = COORD_BITS_DEF;
	localparam int IW = ID_BITS_DEF;
	localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

	typedef struct packed {
		logic signed [CW-1:0] a_x;
		logic signed [CW-1:0] a_y;
		logic [DIM_BITS-1:0] a_w;
		logic [DIM_BITS-1:0] a_h;
		logic signed [CW-1:0] b_x;
		logic signed [CW-1:0] b_y;
		logic [DIM_BITS-1:0] b_w;
		logic [DIM_BITS-1:0] b_h;
		logic [IW-1:0] other_id;
	} rect_pair_t;

	typedef struct packed {
		logic can_up;
		logic can_down;
		logic can_left;
		logic can_right;
		logic touch_top;
		logic touch_bottom;
		logic touch_left;
		logic touch_right;
	} move_flags_t;

	class latch_flags_board;
		bit mode = MODE_A_MOVES;
		int margin = int'(MARGIN_RESET);
		bit latched[4];
		int sa_x[4];
		int sa_y[4];
		int sb_x[4];
		int sb_y[4];
		bit [IW-1:0] saved_id[4];
		move_flags_t flags_due[$];
		int errors;
		int checked;
		int ties;
		int releases;
		int hits[4];

		function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
			case (idx)
				REG_RELEASE_MODE: mode = val[0];
				REG_EDGE_MARGIN: margin = int'(val);
				default: ;
			endcase
		endfunction

		function void take_pair(rect_pair_t w);
			int ax, ay, bx, by, ar, ab, br, bb;
			int pen[4];
			bit blk[4];
			bit won, rel;
			move_flags_t f;
			ax = int'(w.a_x);
			ay = int'(w.a_y);
			bx = int'(w.b_x);
			by = int'(w.b_y);
			ar = ax + int'(w.a_w) + margin;
			ab = ay + int'(w.a_h) + margin;
			br = bx + int'(w.b_w) + margin;
			bb = by + int'(w.b_h) + margin;
			if (ax < br && ar > bx && ay < bb && ab > by) begin
				pen[SIDE_TOP] = ab - by;
				pen[SIDE_BOTTOM] = bb - ay;
				pen[SIDE_LEFT] = ar - bx;
				pen[SIDE_RIGHT] = br - ax;
				won = 0;
				for (int s = 0; s < 4; s++) begin
					if (pen[s] < pen[(s + 1) % 4] && pen[s] < pen[(s + 2) % 4] &&
							pen[s] < pen[(s + 3) % 4]) begin
						latched[s] = 1;
						sa_x[s] = ax;
						sa_y[s] = ay;
						sb_x[s] = bx;
						sb_y[s] = by;
						saved_id[s] = w.other_id;
						hits[s]++;
						won = 1;
					end
				end
				if (!won)
					ties++;
			end
			for (int s = 0; s < 4; s++) begin
				blk[s] = latched[s] && (mode == MODE_A_MOVES || saved_id[s] == w.other_id);
				rel = 0;
				if (blk[s]) begin
					if (mode == MODE_A_MOVES) begin
						case (side_t'(s))
							SIDE_TOP: rel = ay < sa_y[s] || ax != sa_x[s];
							SIDE_BOTTOM: rel = ay > sa_y[s] || ax != sa_x[s];
							SIDE_LEFT: rel = ax < sa_x[s] || ay != sa_y[s];
							default: rel = ax > sa_x[s] || ay != sa_y[s];
						endcase
					end else begin
						case (side_t'(s))
							SIDE_TOP: rel = by > sb_y[s] || bx != sb_x[s];
							SIDE_BOTTOM: rel = by < sb_y[s] || bx != sb_x[s];
							SIDE_LEFT: rel = bx > sb_x[s] || by != sb_y[s];
							default: rel = bx < sb_x[s] || by != sb_y[s];
						endcase
					end
				end
				if (rel) begin
					latched[s] = 0;
					releases++;
				end
			end
			f.can_up = !blk[SIDE_BOTTOM];
			f.can_down = !blk[SIDE_TOP];
			f.can_left = !blk[SIDE_RIGHT];
			f.can_right = !blk[SIDE_LEFT];
			f.touch_top = latched[SIDE_TOP];
			f.touch_bottom = latched[SIDE_BOTTOM];
			f.touch_left = latched[SIDE_LEFT];
			f.touch_right = latched[SIDE_RIGHT];
			flags_due.push_back(f);
		endfunction

		task report(string msg);
			errors++;
			$display("[%0t] MISMATCH: %s", $time, msg);
		endtask

		task same_bit(string field, logic seen, logic want);
			if (seen !== want)
				report($sformatf("result %0d: %s is %b, predicted %b", checked, field, seen, want));
		endtask

		task check_flags(move_flags_t got);
			move_flags_t e;
			if (flags_due.size() == 0) begin
				report($sformatf("result word %b with nothing outstanding", got));
				return;
			end
			e = flags_due.pop_front();
			checked++;
			same_bit("can_move_up", got.can_up, e.can_up);
			same_bit("can_move_down", got.can_down, e.can_down);
			same_bit("can_move_left", got.can_left, e.can_left);
			same_bit("can_move_right", got.can_right, e.can_right);
			same_bit("touch_top", got.touch_top, e.touch_top);
			same_bit("touch_bottom", got.touch_bottom, e.touch_bottom);
			same_bit("touch_left", got.touch_left, e.touch_left);
			same_bit("touch_right", got.touch_right, e.touch_right);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_idx = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic out_stall = 1'b0;
	rect_pair_t drv = '0;
	logic in_stall;
	logic out_valid;
	logic can_move_up, can_move_down, can_move_left, can_move_right;
	logic touch_top, touch_bottom, touch_left, touch_right;
	bit calm = 1'b0;
	int cur_margin = int'(MARGIN_RESET);
	int words_sent = 0;
	latch_flags_board board;

	aabb_side_collision_latch_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.a_x(drv.a_x),
		.a_y(drv.a_y),
		.a_w(drv.a_w),
		.a_h(drv.a_h),
		.b_x(drv.b_x),
		.b_y(drv.b_y),
		.b_w(drv.b_w),
		.b_h(drv.b_h),
		.other_id(drv.other_id),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.can_move_up(can_move_up),
		.can_move_down(can_move_down),
		.can_move_left(can_move_left),
		.can_move_right(can_move_right),
		.touch_top(touch_top),
		.touch_bottom(touch_bottom),
		.touch_left(touch_left),
		.touch_right(touch_right)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				board.take_pair(drv);
			if (out_valid && !out_stall)
				board.check_flags({can_move_up, can_move_down, can_move_left, can_move_right,
					touch_top, touch_bottom, touch_left, touch_right});
		end
	end

	always @(posedge clk) out_stall <= !calm && ($urandom_range(99) < 6);

	task automatic send_word(rect_pair_t w);
		while (!calm && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		drv <= w;
		do @(posedge clk); while (in_stall);
		words_sent++;
	endtask

	// drop valid and hold until every outstanding word has come back
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.flags_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_regs(logic mode, logic [CFG_DATA_BITS-1:0] margin);
		logic [CFG_DATA_BITS-1:0] mode_word;
		mode_word = CFG_DATA_BITS'($urandom);
		mode_word[0] = mode;
		cfg_we <= 1'b1;
		cfg_idx <= REG_RELEASE_MODE;
		cfg_data <= mode_word;
		@(posedge clk);
		board.set_reg(REG_RELEASE_MODE, mode_word);
		cfg_idx <= REG_EDGE_MARGIN;
		cfg_data <= margin;
		@(posedge clk);
		board.set_reg(REG_EDGE_MARGIN, margin);
		cfg_we <= 1'b0;
		cur_margin = int'(margin);
	endtask

	// place A against one side of B, sunk in by depth
	function automatic rect_pair_t make_hit(side_t side, int bx, int by, int bw, int bh,
			int aw, int ah, int depth, int off, int id);
		rect_pair_t w;
		int ax, ay;
		case (side)
			SIDE_TOP: begin
				ax = bx + off;
				ay = by - (ah + cur_margin) + depth;
			end
			SIDE_BOTTOM: begin
				ax = bx + off;
				ay = by + bh + cur_margin - depth;
			end
			SIDE_LEFT: begin
				ax = bx - (aw + cur_margin) + depth;
				ay = by + off;
			end
			default: begin
				ax = bx + bw + cur_margin - depth;
				ay = by + off;
			end
		endcase
		w.a_x = CW'(ax);
		w.a_y = CW'(ay);
		w.a_w = DIM_BITS'(aw);
		w.a_h = DIM_BITS'(ah);
		w.b_x = CW'(bx);
		w.b_y = CW'(by);
		w.b_w = DIM_BITS'(bw);
		w.b_h = DIM_BITS'(bh);
		w.other_id = IW'(id);
		return w;
	endfunction

	task automatic directed_a_moves();
		rect_pair_t w;
		w = '0;
		send_word(w);
		w = '1;
		{w.a_x, w.a_y, w.b_x, w.b_y} = {CMAX, CMAX, CMAX, CMAX};
		send_word(w);
		w = '0;
		{w.a_x, w.a_y, w.b_x, w.b_y} = {CMIN, CMIN, CMIN, CMIN};
		send_word(w);
		w = '1;
		{w.a_x, w.a_y, w.b_x, w.b_y} = {CMIN, CMIN, CMAX, CMAX};
		w.other_id = '0;
		send_word(w);
		w = '1;
		{w.a_x, w.a_y, w.b_x, w.b_y} = {CMAX, CMAX, CMAX - CW'(10), CMAX};
		send_word(w);
		w = make_hit(SIDE_TOP, 100, 100, 20, 20, 16, 16, 1, 0, 5);
		send_word(w);
		send_word(w);
		w.a_y = w.a_y - CW'(1);
		send_word(w);
		w = make_hit(SIDE_BOTTOM, 100, 100, 20, 20, 16, 16, 1, 0, 5);
		send_word(w);
		w.a_y = w.a_y + CW'(1);
		send_word(w);
		w = make_hit(SIDE_LEFT, 100, 100, 20, 20, 16, 16, 1, 0, 5);
		send_word(w);
		w.a_x = w.a_x - CW'(1);
		send_word(w);
		w = make_hit(SIDE_RIGHT, 100, 100, 20, 20, 16, 16, 1, 0, 5);
		send_word(w);
		w.a_x = w.a_x + CW'(1);
		send_word(w);
		w = make_hit(SIDE_TOP, 100, 100, 20, 20, 16, 16, 1, 0, 5);
		send_word(w);
		w.a_x = w.a_x + CW'(40);
		send_word(w);
		w = make_hit(SIDE_LEFT, 100, 100, 20, 20, 16, 16, 1, 0, 5);
		send_word(w);
		w.a_y = w.a_y + CW'(40);
		send_word(w);
		w = make_hit(SIDE_BOTTOM, 100, 100, 20, 20, 16, 16, 1, 0, 5);
		send_word(w);
		w = make_hit(SIDE_TOP, 100, 100, 20, 20, 20, 20, 0, 0, 5);
		w.a_y = w.b_y;
		send_word(w);
	endtask

	task automatic directed_b_moves();
		rect_pair_t w;
		w = make_hit(SIDE_LEFT, -200, -200, 30, 30, 10, 10, 1, 0, 7);
		send_word(w);
		w.other_id = IW'(8);
		send_word(w);
		w.other_id = IW'(7);
		w.b_x = w.b_x + CW'(1);
		send_word(w);
		w = make_hit(SIDE_TOP, -200, -200, 30, 30, 10, 10, 1, 0, 7);
		send_word(w);
		w.b_x = w.b_x + CW'(50);
		send_word(w);
	endtask

	// one contact followed by a short run of mostly small moves of either rectangle, id changes and fresh contacts
	task automatic run_scenario();
		int bx, by, bw, bh, aw, ah, id;
		rect_pair_t w;
		bx = $urandom_range(60000) - 30000;
		by = $urandom_range(60000) - 30000;
		bw = $urandom_range(48, 4);
		bh = $urandom_range(48, 4);
		aw = $urandom_range(48, 4);
		ah = $urandom_range(48, 4);
		id = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(3);
		w = make_hit(side_t'($urandom_range(3)), bx, by, bw, bh, aw, ah,
			$urandom_range(4, 1), $urandom_range(6) - 3, id);
		send_word(w);
		repeat ($urandom_range(8, 2)) begin
			case ($urandom_range(9))
				0, 1, 2: ;
				3: w.a_x = CW'($signed(w.a_x) + ($urandom_range(1) ? 1 : -1));
				4: w.a_y = CW'($signed(w.a_y) + ($urandom_range(1) ? 1 : -1));
				5: w.b_x = CW'($signed(w.b_x) + ($urandom_range(1) ? 1 : -1));
				6: w.b_y = CW'($signed(w.b_y) + ($urandom_range(1) ? 1 : -1));
				7: w.other_id = IW'($urandom_range(3));
				8: w.a_x = CW'($signed(w.a_x) + int'($urandom_range(200)) - 100);
				default: w = make_hit(side_t'($urandom_range(3)), int'(w.b_x), int'(w.b_y),
					int'(w.b_w), int'(w.b_h), int'(w.a_w), int'(w.a_h), $urandom_range(4, 1),
					$urandom_range(6) - 3, int'(w.other_id));
			endcase
			send_word(w);
		end
	endtask

	task automatic send_noise();
		rect_pair_t w;
		w.a_x = CW'($urandom);
		w.a_y = CW'($urandom);
		w.a_w = DIM_BITS'($urandom);
		w.a_h = DIM_BITS'($urandom);
		w.b_x = CW'($urandom);
		w.b_y = CW'($urandom);
		w.b_w = DIM_BITS'($urandom);
		w.b_h = DIM_BITS'($urandom);
		w.other_id = IW'($urandom);
		if ($urandom_range(1)) begin
			w.a_w = DIM_BITS'($urandom_range(63));
			w.a_h = DIM_BITS'($urandom_range(63));
			w.b_w = DIM_BITS'($urandom_range(63));
			w.b_h = DIM_BITS'($urandom_range(63));
			w.b_x = CW'($signed(w.a_x) + int'($urandom_range(128)) - 64);
			w.b_y = CW'($signed(w.a_y) + int'($urandom_range(128)) - 64);
		end
		send_word(w);
	endtask

	initial begin
		logic phase_mode [6];
		int phase_margin [6];
		int stop_at;
		int guard;
		phase_mode = '{MODE_B_MOVES, MODE_B_MOVES, MODE_A_MOVES, MODE_A_MOVES, MODE_B_MOVES,
			MODE_A_MOVES};
		phase_margin = '{15, 0, 0, 15, -1, -1};
		board = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		program_regs(MODE_A_MOVES, MARGIN_RESET);
		directed_a_moves();
		settle();
		program_regs(phase_mode[0], CFG_DATA_BITS'(phase_margin[0]));
		directed_b_moves();
		for (int p = 0; p < 6; p++) begin
			if (p > 0) begin
				settle();
				program_regs(phase_mode[p], phase_margin[p] < 0 ?
					CFG_DATA_BITS'($urandom_range(14, 1)) : CFG_DATA_BITS'(phase_margin[p]));
			end
			calm = (p == 2);
			stop_at = words_sent + 170;
			while (words_sent < stop_at) begin
				if ($urandom_range(99) < 80)
					run_scenario();
				else
					send_noise();
			end
		end
		calm = 1'b0;
		in_valid <= 1'b0;
		@(posedge clk);
		guard = 0;
		while (board.flags_due.size() != 0 && guard < 1000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);
		if (board.flags_due.size() != 0)
			board.report($sformatf("%0d result words never arrived", board.flags_due.size()));
		$display("covered %0d words, %0d results checked, both release modes, margins 0 to 15",
			words_sent, board.checked);
		$display("latched top %0d bottom %0d left %0d right %0d, ties %0d, releases %0d",
			board.hits[SIDE_TOP], board.hits[SIDE_BOTTOM], board.hits[SIDE_LEFT],
			board.hits[SIDE_RIGHT], board.ties, board.releases);
		if (board.errors == 0)
			$display("tb_aabb_side_collision_latch_top: clean");
		else
			$display("tb_aabb_side_collision_latch_top: errors");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("timeout with %0d result words outstanding", board.flags_due.size());
		$display("tb_aabb_side_collision_latch_top: errors");
		$finish;
	end
endmodule
